### hdl/plc_pkg.sv
// Shared types and constants of the precedence level shape classifier.
package plc_pkg;

  localparam int ROW_W = 16;
  localparam int IDX_W = 4;
  localparam int LVL_W = 5;
  localparam int CNT_W = 5;
  localparam int CLS_W = 3;

  localparam logic [CLS_W-1:0] CLS_CYCLE   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_NONINC  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_NONDEC  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_RISEFAL = 3'd3;
  localparam logic [CLS_W-1:0] CLS_FALRISE = 3'd4;
  localparam logic [CLS_W-1:0] CLS_MULTI   = 3'd5;

  // Control broadcast from the sequencer to every node cell.
  typedef struct packed {
    logic             start;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             peel;
    logic             rotate;
    logic [LVL_W-1:0] round;
  } cell_ctrl_t;

  // Control of the level sequence scanner.
  typedef struct packed {
    logic sample;
    logic first;
    logic second;
  } shape_ctrl_t;

endpackage

### hdl/plc_in_if.sv
// Input channel carrying one matrix row per word.
interface plc_in_if;
  logic                      valid;
  logic                      ready;
  logic [plc_pkg::ROW_W-1:0] row_bits;
  logic                      last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

### hdl/plc_out_if.sv
// Output channel carrying one node result per word.
interface plc_out_if;
  logic                      valid;
  logic                      ready;
  logic [plc_pkg::IDX_W-1:0] node_index;
  logic [plc_pkg::LVL_W-1:0] level;
  logic [plc_pkg::CLS_W-1:0] shape_class;
  logic                      last;

  modport source (output valid, output node_index, output level, output shape_class,
                  output last, input ready);
  modport sink (input valid, input node_index, input level, input shape_class,
                input last, output ready);
endinterface

### hdl/plc_cell.sv
// One node cell: holds its matrix row, remaining flag and level.
module plc_cell #(
  parameter int NODES = 16,
  parameter int IDX   = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plc_pkg::cell_ctrl_t       ctrl_i,
  input  logic [plc_pkg::ROW_W-1:0] row_i,
  input  logic                      init_rem_i,
  input  logic [NODES-1:0]          rem_vec_i,
  input  logic [plc_pkg::LVL_W-1:0] next_level_i,
  output logic                      rem_o,
  output logic                      ready_o,
  output logic [plc_pkg::LVL_W-1:0] level_o
);

  logic [NODES-1:0]          row_q;
  logic                      rem_q;
  logic [plc_pkg::LVL_W-1:0] level_q;
  logic                      sel;

  assign sel     = ctrl_i.load && (ctrl_i.load_idx == plc_pkg::IDX_W'(IDX));
  // A node may leave when none of its successors is still remaining.
  assign ready_o = rem_q && ((row_q & rem_vec_i) == '0);
  assign rem_o   = rem_q;
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 1'b0;
    end else if (ctrl_i.start) begin
      rem_q <= init_rem_i;
    end else if (ctrl_i.peel && ready_o) begin
      rem_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      row_q <= row_i[NODES-1:0];
    end
    if (ctrl_i.peel && ready_o) begin
      level_q <= ctrl_i.round;
    end else if (ctrl_i.rotate) begin
      level_q <= next_level_i;
    end
  end

endmodule

### hdl/plc_shape.sv
// Streaming scanner that classifies the shape of the level sequence.
module plc_shape (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plc_pkg::shape_ctrl_t      ctrl_i,
  input  logic [plc_pkg::LVL_W-1:0] level_i,
  output logic [plc_pkg::CLS_W-1:0] shape_class_o
);

  logic [plc_pkg::LVL_W-1:0] prev_q;
  logic rises_q, falls_q, fell_q, rose_q, ok3_q, ok4_q, c3_q, c4_q;
  logic up, down;

  assign up   = level_i > prev_q;
  assign down = level_i < prev_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample) begin
      prev_q <= level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rises_q <= 1'b0;
      falls_q <= 1'b0;
      fell_q  <= 1'b0;
      rose_q  <= 1'b0;
      ok3_q   <= 1'b1;
      ok4_q   <= 1'b1;
      c3_q    <= 1'b0;
      c4_q    <= 1'b0;
    end else if (ctrl_i.sample && ctrl_i.first) begin
      rises_q <= 1'b0;
      falls_q <= 1'b0;
      fell_q  <= 1'b0;
      rose_q  <= 1'b0;
      ok3_q   <= 1'b1;
      ok4_q   <= 1'b1;
      c3_q    <= 1'b0;
      c4_q    <= 1'b0;
    end else if (ctrl_i.sample) begin
      if (up) rises_q <= 1'b1;
      if (down) falls_q <= 1'b1;
      if (ctrl_i.second) begin
        c3_q <= !down;
        c4_q <= !up;
      end
      // Rise then fall breaks when the levels climb again after a fall.
      if (!fell_q) begin
        if (down) fell_q <= 1'b1;
      end else if (up) begin
        ok3_q <= 1'b0;
      end
      // Fall then rise breaks when the levels drop again after a rise.
      if (!rose_q) begin
        if (up) rose_q <= 1'b1;
      end else if (down) begin
        ok4_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (!rises_q) begin
      shape_class_o = plc_pkg::CLS_NONINC;
    end else if (!falls_q) begin
      shape_class_o = plc_pkg::CLS_NONDEC;
    end else if (c3_q && ok3_q) begin
      shape_class_o = plc_pkg::CLS_RISEFAL;
    end else if (c4_q && ok4_q) begin
      shape_class_o = plc_pkg::CLS_FALRISE;
    end else begin
      shape_class_o = plc_pkg::CLS_MULTI;
    end
  end

endmodule

### hdl/precedence_levels_shape_classify_unit.sv
// Top level of the precedence level peeling and shape classification unit.
// Rows load one word per cycle while the sequencer is idle; after the last row, peeling runs
// its level rounds (at most n), then the level scan, and results leave one per cycle while
// the output register is free. No new rows are taken before the last result of a matrix is
// loaded, so the peel round loop of the cell chain and the rotating level chain set the pace.
// Reset clears the sequencer, the remaining flags and the output valid flag and sets the node
// count to 16; stored rows and levels hold no reset value and must be loaded before use.
module precedence_levels_shape_classify_unit #(
  parameter int MAX_NODES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [plc_pkg::CNT_W-1:0] cfg_wdata_i,
  plc_in_if.sink                    in_i,
  plc_out_if.source                 out_o
);

  // Rows are 16 bits wide, so no more than 16 nodes can ever be in use.
  localparam int NODES = (MAX_NODES < plc_pkg::ROW_W) ? MAX_NODES : plc_pkg::ROW_W;
  localparam int CW    = $clog2(NODES);
  localparam int RCW   = $clog2(NODES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PEEL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_CYC  = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [plc_pkg::CNT_W-1:0] node_count_q;
  logic [plc_pkg::CNT_W-1:0] n_w;
  logic [RCW-1:0]            row_cnt_q, row_cnt_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [plc_pkg::LVL_W-1:0] round_q, round_d;
  logic [NODES-1:0]          all_mask, rem_vec, rdy_vec;
  logic [plc_pkg::LVL_W-1:0] lvl [NODES];
  plc_pkg::cell_ctrl_t       cell_ctrl;
  plc_pkg::shape_ctrl_t      shape_ctrl;
  logic [plc_pkg::CLS_W-1:0] shape_class;
  logic                      acc, free, ld, ld_last, ld_cyc, cnt_end;

  logic                      ov_q;
  logic [plc_pkg::IDX_W-1:0] idx_q;
  logic [plc_pkg::LVL_W-1:0] lvl_q;
  logic [plc_pkg::CLS_W-1:0] cls_q;
  logic                      last_q;

  // A node count of zero acts as one node, and counts above the chain length saturate.
  always_comb begin
    if (node_count_q == '0) begin
      n_w = plc_pkg::CNT_W'(1);
    end else if (node_count_q > plc_pkg::CNT_W'(NODES)) begin
      n_w = plc_pkg::CNT_W'(NODES);
    end else begin
      n_w = node_count_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      all_mask[i] = plc_pkg::CNT_W'(i) < n_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= plc_pkg::CNT_W'(16);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // The chain of node cells. During the scan and output phases the levels rotate
  // toward cell 0, and the cell at position n-1 takes the level of cell 0.
  for (genvar i = 0; i < NODES; i++) begin : g_cell
    logic [plc_pkg::LVL_W-1:0] next_lvl;
    if (i == NODES - 1) begin : g_tail
      assign next_lvl = lvl[0];
    end else begin : g_mid
      assign next_lvl = (plc_pkg::CNT_W'(i + 1) == n_w) ? lvl[0] : lvl[i+1];
    end
    plc_cell #(
      .NODES(NODES),
      .IDX  (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .row_i       (in_i.row_bits),
      .init_rem_i  (all_mask[i]),
      .rem_vec_i   (rem_vec),
      .next_level_i(next_lvl),
      .rem_o       (rem_vec[i]),
      .ready_o     (rdy_vec[i]),
      .level_o     (lvl[i])
    );
  end

  plc_shape u_shape (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (shape_ctrl),
    .level_i      (lvl[0]),
    .shape_class_o(shape_class)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign free       = !ov_q || out_o.ready;
  assign cnt_end    = plc_pkg::CNT_W'(cnt_q) == (n_w - plc_pkg::CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    row_cnt_d  = row_cnt_q;
    cnt_d      = cnt_q;
    round_d    = round_q;
    cell_ctrl  = '0;
    shape_ctrl = '0;
    ld         = 1'b0;
    ld_last    = 1'b0;
    ld_cyc     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          // Rows past the node count are dropped.
          if (plc_pkg::CNT_W'(row_cnt_q) < n_w) begin
            cell_ctrl.load     = 1'b1;
            cell_ctrl.load_idx = plc_pkg::IDX_W'(row_cnt_q);
            row_cnt_d          = row_cnt_q + RCW'(1);
          end
          if (in_i.last_row) begin
            cell_ctrl.start = 1'b1;
            row_cnt_d       = '0;
            round_d         = '0;
            state_d         = S_PEEL;
          end
        end
      end
      S_PEEL: begin
        if (rdy_vec == '0) begin
          // Nothing can leave this round, so the graph holds a cycle.
          state_d = S_CYC;
        end else begin
          cell_ctrl.peel  = 1'b1;
          cell_ctrl.round = round_q + plc_pkg::LVL_W'(1);
          round_d         = round_q + plc_pkg::LVL_W'(1);
          if ((rem_vec & ~rdy_vec) == '0) begin
            cnt_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        shape_ctrl.sample = 1'b1;
        shape_ctrl.first  = (cnt_q == '0);
        shape_ctrl.second = (cnt_q == CW'(1));
        cell_ctrl.rotate  = 1'b1;
        if (cnt_end) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_OUT: begin
        if (free) begin
          ld               = 1'b1;
          ld_last          = cnt_end;
          cell_ctrl.rotate = 1'b1;
          if (cnt_end) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      S_CYC: begin
        if (free) begin
          ld_cyc  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_cnt_q <= '0;
      cnt_q     <= '0;
      round_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      cnt_q     <= cnt_d;
      round_q   <= round_d;
      if (ld || ld_cyc) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output register: the finished word waits here while the sequencer moves on.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      idx_q  <= plc_pkg::IDX_W'(cnt_q);
      lvl_q  <= lvl[0];
      cls_q  <= shape_class;
      last_q <= ld_last;
    end else if (ld_cyc) begin
      idx_q  <= '0;
      lvl_q  <= '0;
      cls_q  <= plc_pkg::CLS_CYCLE;
      last_q <= 1'b1;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.node_index  = idx_q;
  assign out_o.level       = lvl_q;
  assign out_o.shape_class = cls_q;
  assign out_o.last        = last_q;

`ifndef SYNTHESIS
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEL) |-> ((rem_vec & ~all_mask) == '0))
    else $error("remaining node outside the active range");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEL) |-> (round_q < n_w))
    else $error("peel round count exceeds node count");

  a_peel_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEL && rdy_vec != '0) |=>
      ($countones(rem_vec) < $past($countones(rem_vec))))
    else $error("peel round removed no node");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && ld_last) |=> (state_q == S_IDLE && ov_q && last_q))
    else $error("final result did not return the sequencer to idle");

  a_cycle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && cls_q == plc_pkg::CLS_CYCLE) |-> (lvl_q == '0 && idx_q == '0 && last_q))
    else $error("cycle result carries a nonzero payload");
`endif

endmodule

### sim/plc_result_checker.sv
// Result checker of the precedence level shape classifier: predicts levels and classes and compares.
`timescale 1ns / 1ps

module plc_result_checker #(
  parameter int MAX_NODES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [plc_pkg::CNT_W-1:0] cfg_wdata_i,
  plc_in_if                         row_mon_i,
  plc_out_if                        res_mon_i,
  output int                        mismatch_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [plc_pkg::IDX_W-1:0] node_index;
    logic [plc_pkg::LVL_W-1:0] level;
    logic [plc_pkg::CLS_W-1:0] shape_class;
    logic                      last;
  } node_result_t;

  logic [plc_pkg::CNT_W-1:0] node_count_q;
  logic [plc_pkg::ROW_W-1:0] rows_q [16];
  logic [plc_pkg::LVL_W-1:0] levels_q [16];
  int                        fill_q;
  int                        mismatches = 0;
  int                        pending = 0;
  node_result_t              pending_levels [$];

  assign mismatch_o = mismatches;
  assign pending_o  = pending;

  function automatic int live_nodes(input logic [plc_pkg::CNT_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n < 1) n = 1;
    if (n > plc_pkg::ROW_W) n = plc_pkg::ROW_W;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic logic [plc_pkg::CLS_W-1:0] shape_of(input int n);
    bit rises, falls, turned, ok;
    rises = 1'b0;
    falls = 1'b0;
    for (int i = 1; i < n; i++) begin
      if (levels_q[i] > levels_q[i-1]) rises = 1'b1;
      if (levels_q[i] < levels_q[i-1]) falls = 1'b1;
    end
    if (!rises) return plc_pkg::CLS_NONINC;
    if (!falls) return plc_pkg::CLS_NONDEC;
    if (n <= 2) return plc_pkg::CLS_MULTI;
    if (levels_q[1] >= levels_q[0]) begin
      // Once the sequence has fallen it may not rise again.
      turned = 1'b0;
      ok = 1'b1;
      for (int i = 1; i < n; i++) begin
        if (!turned) begin
          if (levels_q[i] < levels_q[i-1]) turned = 1'b1;
        end else if (levels_q[i] > levels_q[i-1]) begin
          ok = 1'b0;
        end
      end
      if (ok) return plc_pkg::CLS_RISEFAL;
    end
    if (levels_q[1] <= levels_q[0]) begin
      turned = 1'b0;
      ok = 1'b1;
      for (int i = 1; i < n; i++) begin
        if (!turned) begin
          if (levels_q[i] > levels_q[i-1]) turned = 1'b1;
        end else if (levels_q[i] < levels_q[i-1]) begin
          ok = 1'b0;
        end
      end
      if (ok) return plc_pkg::CLS_FALRISE;
    end
    return plc_pkg::CLS_MULTI;
  endfunction

  task automatic peel_and_classify(input logic [plc_pkg::ROW_W-1:0] row, input logic last_row);
    int                        n;
    logic [plc_pkg::ROW_W:0]   span;
    logic [plc_pkg::ROW_W-1:0] all, remain, peeled;
    logic [plc_pkg::LVL_W-1:0] rnd;
    logic [plc_pkg::CLS_W-1:0] cls;
    node_result_t              res;
    n = live_nodes(node_count_q);
    if (fill_q < n) begin
      rows_q[fill_q] = row;
      fill_q++;
    end
    if (!last_row) return;
    fill_q = 0;
    span   = (17'd1 << n) - 17'd1;
    all    = span[plc_pkg::ROW_W-1:0];
    remain = all;
    rnd    = '0;
    while (remain != '0) begin
      rnd++;
      peeled = '0;
      for (int i = 0; i < n; i++) begin
        if (remain[i] && (rows_q[i] & all & remain) == '0) peeled[i] = 1'b1;
      end
      if (peeled == '0) begin
        // Nothing could be removed, so the matrix holds a cycle.
        res.node_index  = '0;
        res.level       = '0;
        res.shape_class = plc_pkg::CLS_CYCLE;
        res.last        = 1'b1;
        pending_levels.push_back(res);
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (peeled[i]) levels_q[i] = rnd;
      end
      remain &= ~peeled;
    end
    cls = shape_of(n);
    for (int i = 0; i < n; i++) begin
      res.node_index  = plc_pkg::IDX_W'(i);
      res.level       = levels_q[i];
      res.shape_class = cls;
      res.last        = (i == n - 1);
      pending_levels.push_back(res);
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  task automatic check_result();
    node_result_t want;
    if (pending_levels.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual node %0d level %0d class %0d last %0d",
               $time, res_mon_i.node_index, res_mon_i.level, res_mon_i.shape_class,
               res_mon_i.last);
      return;
    end
    want = pending_levels.pop_front();
    if (res_mon_i.node_index !== want.node_index)
      report_field("node_index", int'(want.node_index), int'(res_mon_i.node_index));
    if (res_mon_i.level !== want.level)
      report_field("level", int'(want.level), int'(res_mon_i.level));
    if (res_mon_i.shape_class !== want.shape_class)
      report_field("shape_class", int'(want.shape_class), int'(res_mon_i.shape_class));
    if (res_mon_i.last !== want.last)
      report_field("last", int'(want.last), int'(res_mon_i.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q = plc_pkg::CNT_W'(16);
      fill_q       = 0;
      pending_levels.delete();
    end else begin
      if (cfg_we_i) node_count_q = cfg_wdata_i;
      if (row_mon_i.valid && row_mon_i.ready) begin
        peel_and_classify(row_mon_i.row_bits, row_mon_i.last_row);
      end
      if (res_mon_i.valid && res_mon_i.ready) check_result();
    end
    pending = pending_levels.size();
  end

endmodule

### sim/precedence_levels_shape_classify_unit_tb.sv
// Testbench top of the precedence level shape classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module precedence_levels_shape_classify_unit_tb;

  // Number of row words to send in total, directed part included.
  localparam int ITEMS = 410;
  // Cycles to let pass once nothing is expected any more: a full peel, scan and drain of
  // the largest matrix with margin.
  localparam int SETTLE = 80;
  // Hard stop. The slowest legal run (every word a final row at 16 nodes, every result
  // word waiting out the longest stall) stays well below this.
  localparam int CYCLE_LIMIT = 1500000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [plc_pkg::CNT_W-1:0] cfg_wdata_i;

  plc_in_if  row_if ();
  plc_out_if res_if ();

  int mismatches;
  int pending;

  // Stimulus bookkeeping: active node count, rows stored in the current matrix, the highest
  // row ever written since reset, and the number of row words stored or ending a matrix.
  int cur_n = 16;
  int fill = 0;
  int rows_seen = 0;
  int rows_sent = 0;
  bit src_steady = 1'b0;

  precedence_levels_shape_classify_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (row_if),
    .out_o       (res_if)
  );

  plc_result_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_mon_i   (row_if),
    .res_mon_i   (res_if),
    .mismatch_o  (mismatches),
    .pending_o   (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Most gaps are short or absent; a few are long enough to back up the whole block.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Same saturation as the block applies to the node count register.
  function automatic int live_nodes(input int v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  // Sends one row word. It is entered and left at a falling edge; valid stays high on return
  // so that a following word without a gap goes out back to back.
  task automatic send_row(input logic [plc_pkg::ROW_W-1:0] row, input logic last);
    int gap;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      row_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_if.valid    <= 1'b1;
    row_if.row_bits <= row;
    row_if.last_row <= last;
    do @(posedge clk_i); while (!row_if.ready);
    @(negedge clk_i);
    // Extra rows beyond the node count are dropped by the block and count only if final.
    if (fill < cur_n || last) rows_sent++;
    if (fill < cur_n) begin
      fill++;
      if (fill > rows_seen) rows_seen = fill;
    end
    if (last) fill = 0;
  endtask

  // Drops valid, waits until every expected result word has come out, then lets the block
  // finish whatever it may still be doing.
  task automatic settle();
    row_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // The register is only written while the block is idle.
  task automatic set_node_count(input int v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= plc_pkg::CNT_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_n = live_nodes(v);
  endtask

  // Builds one matrix at the current node count and sends it. Most matrices are acyclic:
  // each node gets a rank and may only point at nodes of lower rank, and the rank pattern
  // (random, rising, falling, peak, valley) steers the shape of the level sequence. The rest
  // carry a forced cycle, trailing extra rows, an early final row or plain noise.
  task automatic send_matrix();
    int                        n, kind, pat, dens, a, b, cut, extra;
    int                        rank [16];
    logic [plc_pkg::ROW_W-1:0] rows [16];
    logic [plc_pkg::ROW_W:0]   span;
    logic [plc_pkg::ROW_W-1:0] used;
    n    = cur_n;
    span = (17'd1 << n) - 17'd1;
    used = span[plc_pkg::ROW_W-1:0];
    pat  = $urandom_range(0, 4);
    dens = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case (pat)
        0: rank[i] = $urandom_range(0, n - 1);
        1: rank[i] = i;
        2: rank[i] = n - 1 - i;
        3: rank[i] = (i < n - 1 - i) ? i : n - 1 - i;
        default: rank[i] = (2 * i < n) ? n / 2 - i : i - n / 2;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      rows[i] = '0;
      for (int j = 0; j < n; j++) begin
        if (rank[j] < rank[i] && $urandom_range(0, 3) < dens) rows[i][j] = 1'b1;
      end
    end
    // Bits for nodes at or above the node count must not matter.
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < n; i++) rows[i] |= plc_pkg::ROW_W'($urandom) & ~used;
    end
    kind = $urandom_range(0, 99);
    if (kind < 13) begin
      a = $urandom_range(0, n - 1);
      if (n == 1 || $urandom_range(0, 1) == 1) begin
        rows[a][a] = 1'b1;
      end else begin
        b = (a + $urandom_range(1, n - 1)) % n;
        rows[a][b] = 1'b1;
        rows[b][a] = 1'b1;
      end
    end else if (kind >= 95) begin
      for (int i = 0; i < n; i++) rows[i] = plc_pkg::ROW_W'($urandom);
    end
    if (kind >= 78 && kind < 88) begin
      for (int i = 0; i < n; i++) send_row(rows[i], 1'b0);
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) send_row(plc_pkg::ROW_W'($urandom), 1'b0);
      send_row(plc_pkg::ROW_W'($urandom), 1'b1);
    end else if (kind >= 88 && kind < 95 && n > 1 && rows_seen >= n) begin
      // The rows left out keep what the previous matrices stored there.
      cut = $urandom_range(1, n - 1);
      for (int i = 0; i < cut; i++) send_row(rows[i], i == cut - 1);
    end else begin
      for (int i = 0; i < n; i++) send_row(rows[i], i == n - 1);
    end
  endtask

  // The receiver holds ready high for a stretch, sometimes a long one, then stalls for a
  // random gap. Ready changes only at falling edges.
  initial begin : result_sink
    int hold, gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 8);
      repeat (hold) @(negedge clk_i);
      gap = idle_len();
      if (gap > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int v, phase;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    row_if.valid    <= 1'b0;
    row_if.row_bits <= '0;
    row_if.last_row <= 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. A single node without a self edge is class 1; with its diagonal bit
    // set it is a cycle.
    set_node_count(1);
    send_row(16'h0000, 1'b1);
    send_row(16'h0001, 1'b1);
    // A count of zero acts as one node, and every bit above it is ignored.
    set_node_count(0);
    send_row(16'hFFFE, 1'b1);
    // Two nodes: levels 2,1 do not increase, levels 1,2 do not decrease.
    set_node_count(2);
    send_row(16'h0002, 1'b0);
    send_row(16'h0000, 1'b1);
    send_row(16'h0000, 1'b0);
    send_row(16'h0001, 1'b1);
    // Rows past the node count are dropped, the final one included.
    send_row(16'h0000, 1'b0);
    send_row(16'h0000, 1'b0);
    send_row(16'hFFFF, 1'b0);
    send_row(16'hFFFF, 1'b1);
    // Three nodes: levels 1,2,1 rise then fall, levels 2,1,2 fall then rise.
    set_node_count(3);
    send_row(16'h0000, 1'b0);
    send_row(16'h0001, 1'b0);
    send_row(16'h0000, 1'b1);
    send_row(16'h0002, 1'b0);
    send_row(16'h0000, 1'b0);
    send_row(16'h0002, 1'b1);
    // An early final row peels with the two older rows still in place: levels 1,1,2.
    send_row(16'h0000, 1'b1);
    // Four nodes with levels 1,2,1,2 go up and down more than once.
    set_node_count(4);
    send_row(16'h0000, 1'b0);
    send_row(16'h0001, 1'b0);
    send_row(16'h0000, 1'b0);
    send_row(16'h0004, 1'b1);

    // Random part: the extremes of the count register first, then mostly small counts.
    phase = 0;
    while (rows_sent < ITEMS) begin
      case (phase)
        0: v = 16;
        1: v = 31;
        2: v = 17;
        default: v = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 6) : $urandom_range(0, 31);
      endcase
      set_node_count(v);
      src_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) send_matrix();
      phase++;
    end
    src_steady = 1'b0;

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/plc_pkg.sv
hdl/plc_in_if.sv
hdl/plc_out_if.sv
hdl/plc_cell.sv
hdl/plc_shape.sv
hdl/precedence_levels_shape_classify_unit.sv
sim/plc_result_checker.sv
sim/precedence_levels_shape_classify_unit_tb.sv
